### rtl/core/vpd_pkg.sv
// ----------------------------------------------------------------------------
// vpd_pkg: shared types and constants of the voice packet deframer
// Input and result payloads, the front-to-back command entry, event and
// register codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package vpd_pkg;

    // widest channel set the timeout mask can carry
    localparam int VPD_MAX_CH = 16;

    // depth of the command queue between front and back
    localparam int VPD_Q_DEPTH = 4;

    // voice bytes per frame, sized to the 48-bit frame field
    localparam int VPD_FRAME_LEN = 6;

    // configuration port
    localparam int VPD_CFG_IDX_W  = 2;
    localparam int VPD_CFG_DATA_W = 32;
    localparam logic [VPD_CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd0;
    localparam logic [VPD_CFG_IDX_W-1:0] REG_PACKET_MAGIC  = 2'd1;

    // register reset values
    localparam logic [23:0] TIMEOUT_RESET = 24'd300;
    localparam logic [31:0] MAGIC_RESET   = 32'hC2C2C2C2;

    // packet layout
    localparam logic [15:0] POS_SATURATED = 16'hFFFF;
    localparam logic [15:0] RT_MIN_LEN    = 16'd8;

    // event codes
    typedef enum logic [2:0] {
        EV_VOICE    = 3'd0,
        EV_TALK_ON  = 3'd1,
        EV_TALK_OFF = 3'd2,
        EV_TIMEOUT  = 3'd3,
        EV_TRAILING = 3'd4,
        EV_BAD_CHAN = 3'd5
    } t_vpd_kind;

    // one input request
    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_vpd_item;

    // one result request
    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  channel_id;
        logic [47:0] voice_frame;
        logic [2:0]  trailing_count;
        logic        last_of_run;
    } t_vpd_result;

    // classified work for the back end: either a tick with a timeout mask,
    // or a byte with an optional primary event and an optional trailing event
    typedef struct packed {
        logic                  is_tick;
        logic [VPD_MAX_CH-1:0] tmo_mask;
        logic                  p_valid;
        t_vpd_kind             p_kind;
        logic [7:0]            p_chan;
        logic [47:0]           p_frame;
        logic                  t_valid;
        logic [7:0]            t_chan;
        logic [2:0]            t_count;
    } t_vpd_cmd;

endpackage

`default_nettype wire

### rtl/core/voice_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// voice_packet_deframer_unit: top level of the voice packet deframer
// Parses captured radio packets and ticks into talk, voice, trailing,
// timeout and invalid-channel events.
// ----------------------------------------------------------------------------
//
//  channel   | handshake     | payload
//  ----------+---------------+------------------------------------------
//  input     | push / full   | i_item   (action, data_byte, last_byte)
//  result    | pop / empty   | o_result (event_kind .. last_of_run)
//  config    | i_cfg_we      | i_cfg_index, i_cfg_wdata
//
//  The parser takes one request per cycle while full is low; its state
//  updates on the accepting edge and any events go as one command into a
//  four-entry queue. The sequencer sends one result per cycle while its
//  output register is free, so a tick that times out k channels yields k
//  results; full rises only when the queue fills. Synchronous active-low
//  reset clears all packet and channel state and loads the register
//  defaults; the first request may follow directly. A request's first
//  result goes through the queue, r_cur and r_out before empty falls.
//
`default_nettype none

module voice_packet_deframer_unit import vpd_pkg::*; #(
    parameter int CHANNELS    = 4,
    parameter int IDLE_WIDTH  = 24,
    parameter int MAX_VOICE   = 160
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       push,
    output logic                      full,
    input  wire t_vpd_item            i_item,
    input  wire                       pop,
    output logic                      empty,
    output t_vpd_result               o_result,
    input  wire                       i_cfg_we,
    input  wire [VPD_CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [VPD_CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic     accept;
    logic     cmd_wr;
    t_vpd_cmd cmd_in;
    logic     q_full;
    logic     q_valid;
    logic     q_rd;
    t_vpd_cmd q_rdata;

    assign full   = q_full;
    assign accept = push && !q_full;

    // parser and channel state
    vpd_front #(
        .CHANNELS    (CHANNELS),
        .IDLE_WIDTH  (IDLE_WIDTH),
        .MAX_VOICE   (MAX_VOICE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd_wr    (cmd_wr),
        .o_cmd       (cmd_in)
    );

    // command queue
    vpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_wdata (cmd_in),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    // event sequencer and output register
    vpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_rdata),
        .o_cmd_rd    (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

### rtl/core/vpd_front.sv
// ----------------------------------------------------------------------------
// vpd_front: packet parser and channel state
// Tracks byte position through radiotap and MAC headers, checks magic,
// handles push-to-talk, voice assembly and tick timeouts; emits one command
// per input that causes any event.
// ----------------------------------------------------------------------------
`default_nettype none

module vpd_front import vpd_pkg::*; #(
    parameter int CHANNELS    = 4,
    parameter int IDLE_WIDTH  = 24,
    parameter int MAX_VOICE   = 160
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_accept,
    input  wire t_vpd_item            i_item,
    input  wire                       i_cfg_we,
    input  wire [VPD_CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [VPD_CFG_DATA_W-1:0]  i_cfg_wdata,
    output logic                      o_cmd_wr,
    output t_vpd_cmd                  o_cmd
);

    localparam int CW = (IDLE_WIDTH > 24) ? IDLE_WIDTH : 24;
    localparam logic [2:0] FILL_LAST = 3'(VPD_FRAME_LEN - 1);

    // configuration
    logic [23:0] r_timeout;
    logic [31:0] r_magic_cfg;

    // packet state
    logic [15:0] r_pos,   n_pos;
    logic [15:0] r_rt,    n_rt;
    logic [15:0] r_fcw,   n_fcw;
    logic [31:0] r_magic, n_magic;
    logic [7:0]  r_seen,  n_seen;
    logic        r_acc,   n_acc;
    logic [7:0]  r_vc,    n_vc;
    logic [2:0]  r_fill,  n_fill;
    logic [47:0] r_fa,    n_fa;

    // channel state
    logic [CHANNELS-1:0]   r_active, n_active;
    logic [IDLE_WIDTH-1:0] r_idle [CHANNELS];
    logic [IDLE_WIDTH-1:0] n_idle [CHANNELS];

    // header offsets
    logic [15:0] mac_off;
    logic [5:0]  hdr_len;
    logic [15:0] pay_off;
    logic        in_mac;

    t_vpd_cmd cmd;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_magic_cfg <= MAGIC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TIMEOUT_TICKS: r_timeout   <= i_cfg_wdata[23:0];
                REG_PACKET_MAGIC:  r_magic_cfg <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // offsets into the MAC header and the payload
    always_comb begin
        mac_off = r_pos - r_rt;
        hdr_len = (r_fcw[9:8] == 2'b11) ? 6'd30 : 6'd24;
        if (r_fcw[3:2] == 2'b10 && r_fcw[7]) begin
            hdr_len = hdr_len + 6'd2;
        end
        pay_off = mac_off - {10'd0, hdr_len};
        in_mac  = (r_pos >= 16'd4) && (r_rt >= RT_MIN_LEN) && (r_pos >= r_rt);
    end

    // next state and command
    always_comb begin
        logic [IDLE_WIDTH-1:0] v_inc;
        logic [7:0]            v_b;

        v_b      = i_item.data_byte;
        v_inc    = '0;
        n_pos    = r_pos;
        n_rt     = r_rt;
        n_fcw    = r_fcw;
        n_magic  = r_magic;
        n_seen   = r_seen;
        n_acc    = r_acc;
        n_vc     = r_vc;
        n_fill   = r_fill;
        n_fa     = r_fa;
        n_active = r_active;
        n_idle   = r_idle;
        cmd      = '0;

        if (i_accept) begin
            if (i_item.action) begin
                // tick: age every active channel
                cmd.is_tick = 1'b1;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (r_active[i]) begin
                        v_inc = (r_idle[i] != '1) ? r_idle[i] + 1'b1 : r_idle[i];
                        n_idle[i] = v_inc;
                        if (CW'(v_inc) > CW'(r_timeout)) begin
                            n_active[i]    = 1'b0;
                            cmd.tmo_mask[i] = 1'b1;
                        end
                    end
                end
            end else begin
                if (r_pos != POS_SATURATED) begin
                    n_pos = r_pos + 16'd1;
                    if (r_pos == 16'd2) begin
                        n_rt = {r_rt[15:8], v_b};
                    end else if (r_pos == 16'd3) begin
                        n_rt = {v_b, r_rt[7:0]};
                    end else if (in_mac) begin
                        if (mac_off == 16'd0) begin
                            n_fcw = {r_fcw[15:8], v_b};
                        end else if (mac_off == 16'd1) begin
                            n_fcw = {v_b, r_fcw[7:0]};
                        end else if (mac_off >= {10'd0, hdr_len}) begin
                            if (pay_off < 16'd4) begin
                                // magic word, big endian
                                n_magic = {r_magic[23:0], v_b};
                            end else if (pay_off == 16'd4) begin
                                n_seen = v_b;
                            end else if (pay_off == 16'd5) begin
                                // push-to-talk byte
                                if (r_magic == r_magic_cfg) begin
                                    if (r_seen >= 8'(CHANNELS)) begin
                                        cmd.p_valid = 1'b1;
                                        cmd.p_kind  = EV_BAD_CHAN;
                                        cmd.p_chan  = r_seen;
                                    end else begin
                                        for (int i = 0; i < CHANNELS; i++) begin
                                            if (r_seen == 8'(i)) begin
                                                if (v_b == 8'd1) begin
                                                    n_idle[i] = '0;
                                                    n_acc     = 1'b1;
                                                    if (!r_active[i]) begin
                                                        n_active[i] = 1'b1;
                                                        cmd.p_valid = 1'b1;
                                                        cmd.p_kind  = EV_TALK_ON;
                                                        cmd.p_chan  = r_seen;
                                                    end
                                                end else if (r_active[i]) begin
                                                    n_active[i] = 1'b0;
                                                    cmd.p_valid = 1'b1;
                                                    cmd.p_kind  = EV_TALK_OFF;
                                                    cmd.p_chan  = r_seen;
                                                end
                                            end
                                        end
                                    end
                                end
                            end else if (r_acc && r_vc < 8'(MAX_VOICE)) begin
                                // voice byte
                                n_vc = r_vc + 8'd1;
                                n_fa = {r_fa[39:0], v_b};
                                if (r_fill == FILL_LAST) begin
                                    cmd.p_valid = 1'b1;
                                    cmd.p_kind  = EV_VOICE;
                                    cmd.p_chan  = r_seen;
                                    cmd.p_frame = n_fa;
                                    n_fa        = '0;
                                    n_fill      = '0;
                                end else begin
                                    n_fill = r_fill + 3'd1;
                                end
                            end
                        end
                    end
                end

                // end of packet: report leftovers, clear packet state
                if (i_item.last_byte) begin
                    if (n_acc && n_fill != 3'd0) begin
                        cmd.t_valid = 1'b1;
                        cmd.t_chan  = n_seen;
                        cmd.t_count = n_fill;
                    end
                    n_pos   = '0;
                    n_rt    = '0;
                    n_fcw   = '0;
                    n_magic = '0;
                    n_seen  = '0;
                    n_acc   = 1'b0;
                    n_vc    = '0;
                    n_fill  = '0;
                    n_fa    = '0;
                end
            end
        end

        o_cmd    = cmd;
        o_cmd_wr = cmd.p_valid || cmd.t_valid || (cmd.tmo_mask != '0);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_rt     <= '0;
            r_fcw    <= '0;
            r_magic  <= '0;
            r_seen   <= '0;
            r_acc    <= 1'b0;
            r_vc     <= '0;
            r_fill   <= '0;
            r_fa     <= '0;
            r_active <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_idle[i] <= '0;
            end
        end else begin
            r_pos    <= n_pos;
            r_rt     <= n_rt;
            r_fcw    <= n_fcw;
            r_magic  <= n_magic;
            r_seen   <= n_seen;
            r_acc    <= n_acc;
            r_vc     <= n_vc;
            r_fill   <= n_fill;
            r_fa     <= n_fa;
            r_active <= n_active;
            r_idle   <= n_idle;
        end
    end

endmodule

`default_nettype wire

### rtl/core/vpd_queue.sv
// ----------------------------------------------------------------------------
// vpd_queue: command queue between parser and event sequencer
// Small first-word-fall-through queue of classified commands.
// ----------------------------------------------------------------------------
`default_nettype none

module vpd_queue import vpd_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_wr,
    input  wire t_vpd_cmd i_wdata,
    output logic          o_full,
    input  wire           i_rd,
    output logic          o_valid,
    output t_vpd_cmd      o_rdata
);

    localparam int AW = $clog2(VPD_Q_DEPTH);

    t_vpd_cmd        r_mem [VPD_Q_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [AW:0]     r_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_count == (AW+1)'(VPD_Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/vpd_back.sv
// ----------------------------------------------------------------------------
// vpd_back: event sequencer
// Expands each command into its results, in order, one per cycle while the
// output register is free, and holds the oldest result there until popped.
// ----------------------------------------------------------------------------
`default_nettype none

module vpd_back import vpd_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_cmd_valid,
    input  wire t_vpd_cmd i_cmd,
    output logic          o_cmd_rd,
    input  wire           i_pop,
    output logic          o_empty,
    output t_vpd_result   o_result
);

    logic        r_cur_valid, n_cur_valid;
    t_vpd_cmd    r_cur,       n_cur;
    logic        r_out_valid, n_out_valid;
    t_vpd_result r_out,       n_out;

    logic        out_free;
    logic        emit;
    logic        ev_last;
    t_vpd_result ev;
    t_vpd_cmd    cur_after;

    assign out_free = !r_out_valid || i_pop;
    assign emit     = r_cur_valid && out_free;

    // pick the next event of the current command
    always_comb begin
        logic [VPD_MAX_CH-1:0] v_low;
        logic [7:0]            v_idx;

        v_low     = r_cur.tmo_mask & (~r_cur.tmo_mask + 1'b1);
        v_idx     = '0;
        ev        = '0;
        ev_last   = 1'b1;
        cur_after = r_cur;

        for (int i = 0; i < VPD_MAX_CH; i++) begin
            if (v_low[i]) begin
                v_idx = v_idx | 8'(i);
            end
        end

        if (r_cur.is_tick) begin
            ev.event_kind      = EV_TIMEOUT;
            ev.channel_id      = v_idx;
            cur_after.tmo_mask = r_cur.tmo_mask & ~v_low;
            ev_last            = (cur_after.tmo_mask == '0);
        end else if (r_cur.p_valid) begin
            ev.event_kind = r_cur.p_kind;
            ev.channel_id = r_cur.p_chan;
            if (r_cur.p_kind == EV_VOICE) begin
                ev.voice_frame = r_cur.p_frame;
            end
            cur_after.p_valid = 1'b0;
            ev_last           = !r_cur.t_valid;
        end else begin
            ev.event_kind     = EV_TRAILING;
            ev.channel_id     = r_cur.t_chan;
            ev.trailing_count = r_cur.t_count;
            cur_after.t_valid = 1'b0;
        end
        ev.last_of_run = ev_last;
    end

    // advance current command and output register
    always_comb begin
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        o_cmd_rd    = 1'b0;

        if (emit) begin
            n_out       = ev;
            n_out_valid = 1'b1;
            n_cur       = cur_after;
        end

        // load the next command once the current one is finished
        if (!r_cur_valid || (emit && ev_last)) begin
            o_cmd_rd    = i_cmd_valid;
            n_cur_valid = i_cmd_valid;
            if (i_cmd_valid) begin
                n_cur = i_cmd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur_valid <= n_cur_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_out <= n_out;
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

### bench/voice_packet_deframer_unit_test.sv
// ----------------------------------------------------------------------------
// voice_packet_deframer_unit_test: self-checking bench for the voice deframer
// Feeds captured packets byte by byte with ticks mixed in, predicts every
// talk, voice, trailing, timeout and invalid-channel event in a software
// model of the parser, and checks the results in order. Both queue sides
// idle at random and the registers are swept between traffic phases.
// ----------------------------------------------------------------------------

module voice_packet_deframer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vpd_pkg::*;

    // block shape and bench limits
    localparam int          NUM_CHANNELS   = 4;
    localparam int          FRAME_LEN      = 6;
    localparam int          VOICE_LIMIT    = 160;
    localparam logic [23:0] IDLE_CEILING   = 24'hFFFFFF;
    localparam logic        ACT_BYTE       = 1'b0;
    localparam logic        ACT_TICK       = 1'b1;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          TAIL_CYCLES    = 24;
    localparam int          WATCHDOG_LIMIT = 600;
    localparam int          MAX_REPORTS    = 40;

    // parser model plus the queue of events still owed by the block
    class voice_event_tracker;
        logic [23:0]  timeout_limit;
        logic [31:0]  magic_word;
        logic [15:0]  byte_pos;
        logic [15:0]  rt_len;
        logic [15:0]  fc_word;
        logic [31:0]  magic_sr;
        logic [7:0]   chan_byte;
        bit           talk_open;
        int           voice_cnt;
        logic [47:0]  frame_acc;
        bit           chan_active [NUM_CHANNELS];
        logic [23:0]  idle_count [NUM_CHANNELS];
        t_vpd_result  pending_events[$];
        t_vpd_result  step_events[$];
        int           requests_seen;
        int           events_predicted;
        int           errors;

        function void clear_packet();
            byte_pos = '0;
            rt_len = '0;
            fc_word = '0;
            magic_sr = '0;
            chan_byte = '0;
            talk_open = 1'b0;
            voice_cnt = 0;
            frame_acc = '0;
        endfunction

        function new();
            timeout_limit = TIMEOUT_RESET;
            magic_word = MAGIC_RESET;
            clear_packet();
            foreach (chan_active[i]) begin
                chan_active[i] = 1'b0;
                idle_count[i] = '0;
            end
            requests_seen = 0;
            events_predicted = 0;
            errors = 0;
        endfunction

        function void set_register(logic [VPD_CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                REG_TIMEOUT_TICKS: timeout_limit = val[23:0];
                REG_PACKET_MAGIC:  magic_word = val;
                default: ;
            endcase
        endfunction

        function void add_event(t_vpd_kind kind, logic [7:0] chan, logic [47:0] frame,
                                logic [2:0] trail);
            t_vpd_result r;
            r.event_kind = kind;
            r.channel_id = chan;
            r.voice_frame = frame;
            r.trailing_count = trail;
            r.last_of_run = 1'b0;
            step_events.push_back(r);
        endfunction

        // advance the model by one accepted request and queue its events
        function void predict_events(t_vpd_item it);
            int p;
            int m;
            int hdr;
            int q;
            step_events.delete();
            requests_seen++;
            if (it.action == ACT_TICK) begin
                // ticks age active channels in channel order
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (chan_active[i]) begin
                        if (idle_count[i] != IDLE_CEILING) idle_count[i] = idle_count[i] + 24'd1;
                        if (idle_count[i] > timeout_limit) begin
                            chan_active[i] = 1'b0;
                            add_event(EV_TIMEOUT, 8'(i), '0, '0);
                        end
                    end
                end
            end else begin
                p = byte_pos;
                if (byte_pos != POS_SATURATED) begin
                    byte_pos = byte_pos + 16'd1;
                    if (p == 2) begin
                        rt_len[7:0] = it.data_byte;
                    end else if (p == 3) begin
                        rt_len[15:8] = it.data_byte;
                    end else if (p > 3 && rt_len >= RT_MIN_LEN && p >= rt_len) begin
                        // mac header, then magic, channel, talk byte and voice
                        m = p - rt_len;
                        hdr = (fc_word[9:8] == 2'b11) ? 30 : 24;
                        if (fc_word[3:2] == 2'd2 && fc_word[7]) hdr += 2;
                        if (m == 0) begin
                            fc_word[7:0] = it.data_byte;
                        end else if (m == 1) begin
                            fc_word[15:8] = it.data_byte;
                        end else if (m >= hdr) begin
                            q = m - hdr;
                            if (q < 4) begin
                                magic_sr = {magic_sr[23:0], it.data_byte};
                            end else if (q == 4) begin
                                chan_byte = it.data_byte;
                            end else if (q == 5) begin
                                if (magic_sr == magic_word) begin
                                    if (chan_byte >= NUM_CHANNELS) begin
                                        add_event(EV_BAD_CHAN, chan_byte, '0, '0);
                                    end else if (it.data_byte == 8'd1) begin
                                        idle_count[chan_byte] = '0;
                                        talk_open = 1'b1;
                                        if (!chan_active[chan_byte]) begin
                                            chan_active[chan_byte] = 1'b1;
                                            add_event(EV_TALK_ON, chan_byte, '0, '0);
                                        end
                                    end else if (chan_active[chan_byte]) begin
                                        chan_active[chan_byte] = 1'b0;
                                        add_event(EV_TALK_OFF, chan_byte, '0, '0);
                                    end
                                end
                            end else if (talk_open && voice_cnt < VOICE_LIMIT) begin
                                voice_cnt++;
                                frame_acc = {frame_acc[39:0], it.data_byte};
                                if (voice_cnt % FRAME_LEN == 0) begin
                                    add_event(EV_VOICE, chan_byte, frame_acc, '0);
                                    frame_acc = '0;
                                end
                            end
                        end
                    end
                end
                // end of packet: leftover voice bytes, then a clean slate
                if (it.last_byte) begin
                    if (talk_open && voice_cnt % FRAME_LEN != 0)
                        add_event(EV_TRAILING, chan_byte, '0, 3'(voice_cnt % FRAME_LEN));
                    clear_packet();
                end
            end
            if (step_events.size() != 0)
                step_events[step_events.size() - 1].last_of_run = 1'b1;
            foreach (step_events[i]) pending_events.push_back(step_events[i]);
            events_predicted += step_events.size();
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
        endtask

        // compare one popped result against the oldest owed event
        task match_event(t_vpd_result got);
            t_vpd_result want;
            string diffs;
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d chan %0d",
                                          got.event_kind, got.channel_id));
                return;
            end
            want = pending_events.pop_front();
            diffs = "";
            if (got.event_kind !== want.event_kind)
                diffs = {diffs, $sformatf(" kind %0d/%0d", got.event_kind, want.event_kind)};
            if (got.channel_id !== want.channel_id)
                diffs = {diffs, $sformatf(" chan %0d/%0d", got.channel_id, want.channel_id)};
            if (got.voice_frame !== want.voice_frame)
                diffs = {diffs, $sformatf(" frame %h/%h", got.voice_frame, want.voice_frame)};
            if (got.trailing_count !== want.trailing_count)
                diffs = {diffs, $sformatf(" trail %0d/%0d",
                                          got.trailing_count, want.trailing_count)};
            if (got.last_of_run !== want.last_of_run)
                diffs = {diffs, $sformatf(" last %0b/%0b", got.last_of_run, want.last_of_run)};
            if (diffs != "") report_mismatch({"result differs (got/want):", diffs});
        endtask

        task check_leftovers();
            if (pending_events.size() != 0)
                report_mismatch($sformatf("%0d expected results never arrived",
                                          pending_events.size()));
        endtask

        function int pending();
            return pending_events.size();
        endfunction
    endclass

    // block ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    t_vpd_item                  i_item = '0;
    logic                       pop = 1'b0;
    logic                       empty;
    t_vpd_result                o_result;
    logic                       i_cfg_we = 1'b0;
    logic [VPD_CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [VPD_CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    voice_event_tracker tracker = new();
    bit                 steady = 1'b0;
    int                 idle_cycles = 0;

    voice_packet_deframer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .pop         (pop),
        .empty       (empty),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // observe both handshakes at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) tracker.predict_events(i_item);
        if (i_rst_n && pop && !empty) tracker.match_event(o_result);
    end

    // watchdog on cycles without any accepted request or popped result
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls between pops
    initial begin
        int gap;
        forever begin
            gap = steady ? 0 : $urandom_range(0, 4);
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty || !i_rst_n);
        end
    end

    // one input request, after a random gap; push stays high on return
    task automatic send_request(input logic act, input logic [7:0] value, input logic fin);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= '{action: act, data_byte: value, last_byte: fin};
        do @(posedge i_clk); while (full);
    endtask

    // ticks carry random byte and last bits, which the block must ignore
    task automatic send_ticks(input int count);
        repeat (count) send_request(ACT_TICK, 8'($urandom), 1'($urandom));
    endtask

    // radiotap, mac header, magic, channel, talk byte, voice; optional cut
    task automatic send_packet(input logic [15:0] rt_len, input logic [15:0] fc,
                               input logic [31:0] magic, input logic [7:0] chan,
                               input logic [7:0] talk, input int payload_len,
                               input int cut, input int tick_odds);
        logic [7:0] octets[$];
        int         hdr_len;
        int         rt_fill;
        rt_fill = (rt_len < 4) ? 4 : rt_len;
        for (int i = 0; i < rt_fill; i++) begin
            if (i == 2) octets.push_back(rt_len[7:0]);
            else if (i == 3) octets.push_back(rt_len[15:8]);
            else octets.push_back(8'($urandom));
        end
        hdr_len = (fc[9:8] == 2'b11) ? 30 : 24;
        if (fc[3:2] == 2'd2 && fc[7]) hdr_len += 2;
        octets.push_back(fc[7:0]);
        octets.push_back(fc[15:8]);
        repeat (hdr_len - 2) octets.push_back(8'($urandom));
        for (int i = 3; i >= 0; i--) octets.push_back(magic[8*i +: 8]);
        octets.push_back(chan);
        octets.push_back(talk);
        repeat (payload_len) octets.push_back(8'($urandom));
        if (cut > 0 && cut < octets.size()) octets = octets[0:cut-1];
        foreach (octets[i]) begin
            if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1) send_ticks(1);
            send_request(ACT_BYTE, octets[i], i == octets.size() - 1);
        end
    endtask

    // hold off input until every owed result is out and the block settles
    task automatic wait_until_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [VPD_CFG_IDX_W-1:0] idx,
                                  input logic [VPD_CFG_DATA_W-1:0] val);
        wait_until_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_register(idx, val);
    endtask

    // mostly well-formed packets with random content, some broken, some tick noise
    task automatic run_random_phase(input int item_goal, input int event_goal);
        int          item_mark;
        int          event_mark;
        int          pick;
        logic [15:0] rt;
        logic [15:0] fc;
        logic [31:0] magic;
        logic [7:0]  chan;
        logic [7:0]  talk;
        int          voice;
        int          cut;
        item_mark = tracker.requests_seen;
        event_mark = tracker.events_predicted;
        while (tracker.requests_seen - item_mark < item_goal ||
               tracker.events_predicted - event_mark < event_goal) begin
            steady = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                send_ticks($urandom_range(1, 8));
            end else begin
                rt = 16'($urandom_range(8, 20));
                fc = 16'($urandom);
                if ($urandom_range(0, 2) == 0) fc[9:8] = 2'b11;
                if ($urandom_range(0, 2) == 0) begin
                    fc[3:2] = 2'd2;
                    fc[7] = 1'b1;
                end
                magic = tracker.magic_word;
                chan = 8'($urandom_range(0, NUM_CHANNELS - 1));
                talk = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'd1;
                voice = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 175)
                                                    : $urandom_range(0, 40);
                cut = 0;
                case (pick)
                    1: rt = 16'($urandom_range(0, 7));
                    2: magic = magic ^ (32'h1 << $urandom_range(0, 31));
                    3: chan = 8'($urandom_range(NUM_CHANNELS, 255));
                    4: cut = $urandom_range(1, rt + 36);
                    default: ;
                endcase
                send_packet(rt, fc, magic, chan, talk, voice, cut, 12);
            end
        end
        steady = 1'b0;
    endtask

    // stimulus
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed cases at reset register values: both ds bits with qos,
        // one full frame plus a trailing byte, an invalid channel, then a talk on channel 1
        send_packet(16'd8, 16'h0388, MAGIC_RESET, 8'd0, 8'd1, 7, 0, 0);
        send_packet(16'd8, 16'h0008, MAGIC_RESET, 8'd255, 8'd1, 0, 0, 0);
        send_packet(16'd8, 16'h0000, MAGIC_RESET, 8'd1, 8'd1, 0, 0, 0);

        // timeout register set to 1: two channels time out on the same tick
        write_register(REG_TIMEOUT_TICKS, 32'd1);
        send_ticks(2);

        // short random timeout and random magic, with a full drain halfway
        write_register(REG_TIMEOUT_TICKS, 32'($urandom_range(2, 8)));
        write_register(REG_PACKET_MAGIC, $urandom);
        run_random_phase(55, 4);
        wait_until_idle();
        run_random_phase(55, 4);

        // drain and final verdict
        push <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        tracker.check_leftovers();
        if (tracker.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/vpd_pkg.sv
rtl/core/vpd_front.sv
rtl/core/vpd_queue.sv
rtl/core/vpd_back.sv
rtl/core/voice_packet_deframer_unit.sv
bench/voice_packet_deframer_unit_test.sv
